// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// plain invariant
`define ASSERT_ALWAYS(label, expr, msg) `ASSERT_CLK(label, (expr), msg)

`endif

// ===== sv/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Constants, codes and types for the first-free bitmap allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_ENTRIES = 8192;
    localparam int ENTRY_W     = 14;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int NUM_WORDS   = MAX_ENTRIES / WORD_W;
    localparam int ADDR_W      = $clog2(NUM_WORDS);
    localparam int STATUS_W    = 2;

    localparam logic [ENTRY_W-1:0] CFG_RESET = ENTRY_W'(8192);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd3;

    typedef logic [WORD_W-1:0]   word_t;
    typedef logic [ADDR_W-1:0]   waddr_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [BIT_W-1:0]    bidx_t;
    typedef logic [STATUS_W-1:0] status_t;

    typedef struct packed {
        logic   wr_en;
        waddr_t wr_addr;
        word_t  wr_data;
        logic   rd_en;
        waddr_t rd_addr;
    } map_req_t;

    typedef struct packed {
        logic  found;
        bidx_t bit_idx;
    } ffz_rsp_t;

endpackage

// ===== sv/bfa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bfa_cfg_if
// Configuration write channel: managed entry count.
// ----------------------------------------------------------------------------
interface bfa_cfg_if import bfa_pkg::*; ();

    logic   valid;
    logic   ready;
    entry_t entries_in_use;

    modport source (output valid, output entries_in_use, input ready);
    modport sink   (input valid, input entries_in_use, output ready);

endinterface

// ===== sv/bfa_req_if.sv =====
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: allocate or free one entry.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();

    logic   valid;
    logic   ready;
    logic   func;
    entry_t entry_number;

    modport source (output valid, output func, output entry_number, input ready);
    modport sink   (input valid, input func, input entry_number, output ready);

endinterface

// ===== sv/bfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: status, allocated number and free count.
// ----------------------------------------------------------------------------
interface bfa_rsp_if import bfa_pkg::*; ();

    logic    valid;
    logic    ready;
    status_t status;
    entry_t  allocated_number;
    entry_t  free_count;

    modport source (output valid, output status, output allocated_number,
                    output free_count, input ready);
    modport sink   (input valid, input status, input allocated_number,
                    input free_count, output ready);

endinterface

// ===== sv/bfa_map.sv =====
// ----------------------------------------------------------------------------
// bfa_map
// Used-mark bitmap store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bfa_map
    import bfa_pkg::*;
(
    input  logic     clk,
    input  map_req_t req,
    output word_t    rd_data
);

    word_t mem [NUM_WORDS];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bfa_ffz.sv =====
// ----------------------------------------------------------------------------
// bfa_ffz
// Lowest clear bit of one bitmap word, bits at or above the limit masked.
// ----------------------------------------------------------------------------
module bfa_ffz
    import bfa_pkg::*;
(
    input  word_t    data,
    input  waddr_t   word_idx,
    input  entry_t   lim,
    output ffz_rsp_t res
);

    entry_t full_words;
    entry_t word_ext;
    word_t  mask;
    word_t  free_bits;

    always_comb
    begin
        full_words = lim >> BIT_W;
        word_ext   = ENTRY_W'(word_idx);
        if (word_ext < full_words)
        begin
            mask = '1;
        end
        else if (word_ext == full_words)
        begin
            mask = ~({WORD_W{1'b1}} << lim[BIT_W-1:0]);
        end
        else
        begin
            mask = '0;
        end
        free_bits   = ~data & mask;
        res.found   = 1'b0;
        res.bit_idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (free_bits[i])
            begin
                res.found   = 1'b1;
                res.bit_idx = BIT_W'(i);
            end
        end
    end

endmodule

// ===== sv/bitmap_first_free_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator
// Hands out and takes back one-based entry numbers from a used-mark bitmap.
// ----------------------------------------------------------------------------
// Channels: cfg writes the managed entry count; it is accepted on any cycle
// and is only to be written while no request is in flight. req carries func
// (allocate/free) and entry_number; rsp returns status, allocated_number
// and free_count, one per request.
// The bitmap sits in a 256 x 32 store; one word is examined per cycle by
// a single first-clear-bit finder under a small sequencer.
// From the accepting edge, an allocate reads and checks one word at a time up
// to the first clear bit, at most 256 words; a free reads the word, checks
// it and writes it back; a rejected free or an allocate under a zero limit
// goes straight on. Each then passes S_DONE, which loads the output register.
// One request at a time: req.ready is high only while the sequencer is
// idle, so a request is taken only after the last one is through. A
// finished response waits in the output register while the next request
// is taken; a stalled rsp holds the sequencer at the end of that next
// request until the register empties.
// Reset: a clearing pass zeroes all 256 bitmap words; req.ready stays
// low until it ends. The entry count resets to 8192, the used count to 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_first_free_allocator
    import bfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bfa_cfg_if.sink      cfg,
    bfa_req_if.sink      req,
    bfa_rsp_if.source    rsp
);

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_ALLOC_CHK = 3'd2;
    localparam logic [2:0] S_FREE_CHK  = 3'd3;
    localparam logic [2:0] S_DONE      = 3'd4;

    logic [2:0] state_reg, state_next;
    entry_t     lim_cfg_reg, lim_cfg_next;
    waddr_t     word_reg, word_next;
    bidx_t      bit_reg, bit_next;
    status_t    status_reg, status_next;
    entry_t     given_reg, given_next;
    entry_t     used_count_reg, used_count_next;
    logic       rsp_valid_reg, rsp_valid_next;
    status_t    rsp_status_reg, rsp_status_next;
    entry_t     rsp_given_reg, rsp_given_next;
    entry_t     rsp_free_reg, rsp_free_next;

    entry_t     lim;
    entry_t     lim_m1;
    waddr_t     last_word;
    entry_t     num_m1;
    logic       req_accept;
    map_req_t   map_req;
    word_t      rd_data;
    ffz_rsp_t   ffz;

    bfa_map u_map
    (
        .clk     (clk),
        .req     (map_req),
        .rd_data (rd_data)
    );

    bfa_ffz u_ffz
    (
        .data     (rd_data),
        .word_idx (word_reg),
        .lim      (lim),
        .res      (ffz)
    );

    assign lim        = (lim_cfg_reg < ENTRY_W'(MAX_ENTRIES)) ? lim_cfg_reg
                                                              : ENTRY_W'(MAX_ENTRIES);
    assign lim_m1     = lim - ENTRY_W'(1);
    assign last_word  = lim_m1[BIT_W +: ADDR_W];
    assign num_m1     = req.entry_number - ENTRY_W'(1);
    assign req_accept = req.valid && req.ready;

    assign req.ready            = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.allocated_number = rsp_given_reg;
    assign rsp.free_count       = rsp_free_reg;

    always_comb
    begin
        state_next      = state_reg;
        lim_cfg_next    = cfg.valid ? cfg.entries_in_use : lim_cfg_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        status_next     = status_reg;
        given_next      = given_reg;
        used_count_next = used_count_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_given_next  = rsp_given_reg;
        rsp_free_next   = rsp_free_reg;
        map_req         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = word_reg;
                map_req.wr_data = '0;
                if (word_reg == ADDR_W'(NUM_WORDS - 1))
                begin
                    word_next  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    word_next = word_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_accept)
                begin
                    given_next = '0;
                    if (req.func == FUNC_ALLOC)
                    begin
                        if (lim == '0)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            map_req.rd_en   = 1'b1;
                            map_req.rd_addr = '0;
                            word_next       = '0;
                            state_next      = S_ALLOC_CHK;
                        end
                    end
                    else if ((req.entry_number == '0) || (req.entry_number > lim))
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = num_m1[BIT_W +: ADDR_W];
                        word_next       = num_m1[BIT_W +: ADDR_W];
                        bit_next        = num_m1[BIT_W-1:0];
                        state_next      = S_FREE_CHK;
                    end
                end
            end

            S_ALLOC_CHK:
            begin
                if (ffz.found)
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = word_reg;
                    map_req.wr_data = rd_data | (WORD_W'(1) << ffz.bit_idx);
                    used_count_next = used_count_reg + ENTRY_W'(1);
                    given_next      = ENTRY_W'({word_reg, ffz.bit_idx}) + ENTRY_W'(1);
                    status_next     = ST_OK;
                    state_next      = S_DONE;
                end
                else if (word_reg == last_word)
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = word_reg + ADDR_W'(1);
                    word_next       = word_reg + ADDR_W'(1);
                end
            end

            S_FREE_CHK:
            begin
                if (!rd_data[bit_reg])
                begin
                    status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = word_reg;
                    map_req.wr_data = rd_data & ~(WORD_W'(1) << bit_reg);
                    if (used_count_reg != '0)
                    begin
                        used_count_next = used_count_reg - ENTRY_W'(1);
                    end
                    status_next = ST_OK;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_given_next  = given_reg;
                    rsp_free_next   = (lim > used_count_reg) ? (lim - used_count_reg) : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            lim_cfg_reg    <= CFG_RESET;
            word_reg       <= '0;
            used_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lim_cfg_reg    <= lim_cfg_next;
            word_reg       <= word_next;
            used_count_reg <= used_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg        <= bit_next;
        status_reg     <= status_next;
        given_reg      <= given_next;
        rsp_status_reg <= rsp_status_next;
        rsp_given_reg  <= rsp_given_next;
        rsp_free_reg   <= rsp_free_next;
    end

    `ASSERT_CLK(a_scan_bound,
                (state_reg == S_ALLOC_CHK) |-> (word_reg <= last_word),
                "allocate scan past last word")
    `ASSERT_ALWAYS(a_count_bound, used_count_reg <= ENTRY_W'(MAX_ENTRIES),
                   "used count above capacity")
    `ASSERT_CLK(a_given_ok,
                (rsp_valid_reg && (rsp_given_reg != '0)) |-> (rsp_status_reg == ST_OK),
                "number given on failed request")

endmodule

// ===== sim/bitmap_first_free_allocator_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_test
// Self-checking bench for the first-free entry allocator.
// ----------------------------------------------------------------------------
// Drives allocate and free requests over a range of entry-count settings.
// A scoreboard keeps its own used-mark map and predicts status, allocated
// number and free count for each request. Directed requests cover range
// edges, double frees, a zero limit, a clamped limit and marks left above
// a lowered limit. Random phases then mix well-formed traffic with stray
// numbers; request and response stall at random in some phases, never in the last two.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_test;
    import bfa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 65;
    localparam int NUM_PHASES   = 13;
    localparam int QUIET_PHASES = 2;

    class alloc_scoreboard;
        typedef struct {
            status_t status;
            entry_t  number;
            entry_t  free_cnt;
        } outcome_t;

        bit          used_marks[MAX_ENTRIES];
        int unsigned marks_set;
        int unsigned limit_reg;
        outcome_t    expected_q[$];
        int          failures;
        int          checked;
        int          status_seen[4];

        function new();
            foreach (used_marks[i])
                used_marks[i] = 1'b0;
            marks_set = 0;
            limit_reg = CFG_RESET;
            failures  = 0;
            checked   = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function int unsigned eff_limit();
            return (limit_reg < MAX_ENTRIES) ? limit_reg : MAX_ENTRIES;
        endfunction

        function void set_limit(entry_t v);
            limit_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic f, entry_t n);
            int unsigned lim;
            outcome_t    o;
            lim      = eff_limit();
            o.status = ST_OK;
            o.number = '0;
            if (f == FUNC_ALLOC)
            begin
                o.status = ST_FULL;
                for (int i = 0; i < lim; i++)
                begin
                    if (!used_marks[i])
                    begin
                        used_marks[i] = 1'b1;
                        marks_set++;
                        o.number = entry_t'(i + 1);
                        o.status = ST_OK;
                        break;
                    end
                end
            end
            else if (n == 0 || n > lim)
                o.status = ST_RANGE;
            else if (!used_marks[n - 1])
                o.status = ST_ALREADY_FREE;
            else
            begin
                used_marks[n - 1] = 1'b0;
                if (marks_set > 0)
                    marks_set--;
            end
            o.free_cnt = entry_t'((lim > marks_set) ? lim - marks_set : 0);
            expected_q.push_back(o);
        endfunction

        function void check_response(status_t s, entry_t a, entry_t fc);
            outcome_t o;
            if (expected_q.size() == 0)
            begin
                $error("response with no request outstanding: status %0d", s);
                failures++;
                return;
            end
            o = expected_q.pop_front();
            checked++;
            status_seen[o.status]++;
            if (s !== o.status)
            begin
                $error("status: expected %0d, actual %0d", o.status, s);
                failures++;
            end
            if (a !== o.number)
            begin
                $error("allocated_number: expected %0d, actual %0d", o.number, a);
                failures++;
            end
            if (fc !== o.free_cnt)
            begin
                $error("free_count: expected %0d, actual %0d", o.free_cnt, fc);
                failures++;
            end
        endfunction

        // random entry number up to the limit whose mark matches want_used, 0 if none
        function entry_t pick_entry(bit want_used);
            int unsigned lim;
            int unsigned start;
            int unsigned idx;
            lim = eff_limit();
            if (lim == 0)
                return '0;
            start = $urandom_range(0, lim - 1);
            for (int unsigned j = 0; j < lim; j++)
            begin
                idx = (start + j) % lim;
                if (used_marks[idx] == want_used)
                    return entry_t'(idx + 1);
            end
            return '0;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   idling_on;
    int   config_writes;

    alloc_scoreboard book = new();

    bfa_cfg_if cfg_ch ();
    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    bitmap_first_free_allocator dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_request(logic f, entry_t n);
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= f;
        req_ch.entry_number <= n;
        do @(posedge clk); while (!req_ch.ready);
        book.note_request(f, n);
    endtask

    task automatic drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (book.pending() > 0)
            @(posedge clk);
    endtask

    task automatic write_limit(entry_t v);
        @(negedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.entries_in_use <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        book.set_limit(v);
        config_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(int n_items);
        int          alloc_pct;
        int unsigned lim;
        entry_t      num;
        alloc_pct = $urandom_range(30, 80);
        for (int k = 0; k < n_items; k++)
        begin
            lim = book.eff_limit();
            if ($urandom_range(0, 99) < 10)
            begin
                // stray requests
                case ($urandom_range(0, 3))
                    0: send_request(1'($urandom_range(0, 1)), entry_t'($urandom));
                    1: send_request(FUNC_FREE, '0);
                    2: send_request(FUNC_FREE, entry_t'($urandom_range(lim + 1, 16383)));
                    default:
                    begin
                        num = book.pick_entry(1'b0);
                        send_request(FUNC_FREE, (num == 0) ? entry_t'($urandom) : num);
                    end
                endcase
            end
            else if ($urandom_range(0, 99) < alloc_pct)
                send_request(FUNC_ALLOC, entry_t'($urandom));
            else
            begin
                num = book.pick_entry(1'b1);
                if (num == 0)
                    send_request(FUNC_ALLOC, entry_t'($urandom));
                else
                    send_request(FUNC_FREE, num);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
            book.check_response(rsp_ch.status, rsp_ch.allocated_number,
                                rsp_ch.free_count);
    end

    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    // stall watchdog
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no request or response moved for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        entry_t phase_limits[NUM_PHASES];
        phase_limits = '{8, 1, 40, 33, 0, 100, 16383, 64, 5, 8192, 32, 250, 12};

        rst_n                 = 1'b0;
        idling_on             = 1'b1;
        config_writes         = 0;
        req_ch.valid          = 1'b0;
        req_ch.func           = FUNC_ALLOC;
        req_ch.entry_number   = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.entries_in_use = CFG_RESET;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // reset limit: range edges and double free
        send_request(FUNC_FREE, entry_t'(0));
        send_request(FUNC_FREE, entry_t'(8192));
        send_request(FUNC_FREE, entry_t'(8193));
        send_request(FUNC_FREE, entry_t'(16383));
        send_request(FUNC_ALLOC, entry_t'(16383));
        send_request(FUNC_ALLOC, entry_t'(0));
        send_request(FUNC_FREE, entry_t'(1));
        send_request(FUNC_ALLOC, entry_t'(0));
        send_request(FUNC_FREE, entry_t'(2));
        send_request(FUNC_FREE, entry_t'(2));
        drain();

        write_limit(entry_t'(0));
        send_request(FUNC_ALLOC, entry_t'(0));
        send_request(FUNC_FREE, entry_t'(1));
        drain();

        write_limit(entry_t'(3));
        send_request(FUNC_ALLOC, entry_t'(0));
        send_request(FUNC_ALLOC, entry_t'(0));
        send_request(FUNC_ALLOC, entry_t'(0));
        drain();

        // marks 2 and 3 stay set above the lowered limit
        write_limit(entry_t'(1));
        send_request(FUNC_FREE, entry_t'(3));
        send_request(FUNC_ALLOC, entry_t'(0));
        send_request(FUNC_FREE, entry_t'(1));
        drain();

        write_limit(entry_t'(16383));
        send_request(FUNC_ALLOC, entry_t'(0));
        send_request(FUNC_FREE, entry_t'(8192));
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            idling_on = (p < NUM_PHASES - QUIET_PHASES) && ($urandom_range(0, 3) != 0);
            write_limit(phase_limits[p]);
            random_phase(PHASE_ITEMS);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.pending() != 0)
        begin
            $error("%0d responses never arrived", book.pending());
            book.failures++;
        end

        $display("checked %0d responses across %0d entry-count writes, limits 0 to 16383",
                 book.checked, config_writes);
        $display("ok %0d, full %0d, out of range %0d, already free %0d",
                 book.status_seen[ST_OK], book.status_seen[ST_FULL],
                 book.status_seen[ST_RANGE], book.status_seen[ST_ALREADY_FREE]);
        if (book.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
